@@ rtl/core/skos_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skos_pkg: shared types and defaults for the skyline outline sweep
// Event kind codes, cell control structs and default sizes.
// ----------------------------------------------------------------------------
package skos_pkg;

  localparam int DEF_MAX_ACTIVE  = 64;
  localparam int DEF_HEIGHT_BITS = 16;
  localparam int DEF_POS_BITS    = 16;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_END   = 1'b1
  } kind_t;

  // Operation broadcast to every cell of the chain at once.
  typedef struct packed {
    logic ins;
    logic rem;
  } skos_op_t;

  // Status that a cell hands to its neighbors and to the top level.
  typedef struct packed {
    logic valid;
    logic keep;   // holds a value at or above the broadcast height
    logic match;  // holds exactly the broadcast height
  } skos_flags_t;

endpackage

@@ rtl/core/skos_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skos_cell: one slot of the sorted height chain
// Holds one active height; the chain is kept in descending order, so an
// insert shifts smaller entries down and a removal pulls entries up.
// ----------------------------------------------------------------------------
module skos_cell
  import skos_pkg::*;
#(
  parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  skos_op_t               op,
  input  logic [HEIGHT_BITS-1:0] h,
  input  skos_flags_t            left_flags,
  input  logic [HEIGHT_BITS-1:0] left_value,
  input  logic                   right_valid,
  input  logic [HEIGHT_BITS-1:0] right_value,
  output skos_flags_t            flags,
  output logic [HEIGHT_BITS-1:0] value
);

  logic                   valid;
  logic                   valid_next;
  logic [HEIGHT_BITS-1:0] value_next;
  logic                   shift;

  assign flags.valid = valid;
  assign flags.keep  = valid && (value >= h);
  assign flags.match = valid && (value == h);
  assign shift       = valid && (value <= h);

  always_comb begin
    valid_next = valid;
    value_next = value;
    if (op.ins) begin
      if (!flags.keep) begin
        if (left_flags.keep) begin
          valid_next = 1'b1;
          value_next = h;
        end else begin
          valid_next = left_flags.valid;
          value_next = left_value;
        end
      end
    end else if (op.rem && shift) begin
      valid_next = right_valid;
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ rtl/core/skyline_outline_sweep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skyline_outline_sweep: skyline outline from sorted building edge events
// Active heights live in a descending chain of cells; the head is the
// current maximum. On a position's last event, emits a change if it moved.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  kind, position, height, last_at_position
//   out      out_valid/ out_stall out_position, out_height, overflow
//
// One item per cycle: the whole chain inserts or deletes against the
// broadcast height at once, and the result register loads in the same
// edge. Reset clears all cell valid bits at once, so no clearing pass is
// needed. Input stalls only while a result is held and the output is stalled.
// ----------------------------------------------------------------------------
module skyline_outline_sweep
  import skos_pkg::*;
#(
  parameter int MAX_ACTIVE  = DEF_MAX_ACTIVE,
  parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
  parameter int POS_BITS    = DEF_POS_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   kind,
  input  logic [POS_BITS-1:0]    position,
  input  logic [HEIGHT_BITS-1:0] height,
  input  logic                   last_at_position,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [POS_BITS-1:0]    out_position,
  output logic [HEIGHT_BITS-1:0] out_height,
  output logic                   overflow
);

  skos_flags_t            flags [MAX_ACTIVE];
  logic [HEIGHT_BITS-1:0] values[MAX_ACTIVE];
  logic [MAX_ACTIVE-1:0]  match_vec;

  skos_op_t               op;
  logic                   accept;
  logic                   hit;
  logic                   full;
  logic                   overflow_seen;
  logic                   overflow_seen_next;
  logic [HEIGHT_BITS-1:0] last_emitted;
  logic [HEIGHT_BITS-1:0] top_next;
  logic                   emit;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = flags[MAX_ACTIVE-1].valid;
  assign hit      = |match_vec;

  assign op.ins = accept && (kind == KIND_START) && !full;
  assign op.rem = accept && (kind == KIND_END) && hit;

  assign overflow_seen_next = overflow_seen || (accept && (kind == KIND_START) && full);

  genvar i;
  generate
    for (i = 0; i < MAX_ACTIVE; i++) begin : g_cell
      skos_flags_t            lf;
      logic [HEIGHT_BITS-1:0] lv;
      logic                   rv;
      logic [HEIGHT_BITS-1:0] rval;

      if (i == 0) begin : g_head
        assign lf = '{valid: 1'b1, keep: 1'b1, match: 1'b0};
        assign lv = '0;
      end else begin : g_body
        assign lf = flags[i-1];
        assign lv = values[i-1];
      end

      if (i == MAX_ACTIVE - 1) begin : g_tail
        assign rv   = 1'b0;
        assign rval = '0;
      end else begin : g_inner
        assign rv   = flags[i+1].valid;
        assign rval = values[i+1];
      end

      skos_cell #(
        .HEIGHT_BITS(HEIGHT_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .op         (op),
        .h          (height),
        .left_flags (lf),
        .left_value (lv),
        .right_valid(rv),
        .right_value(rval),
        .flags      (flags[i]),
        .value      (values[i])
      );

      assign match_vec[i] = flags[i].match;
    end
  endgenerate

  // Head of the chain after this item's update; ground when the chain is empty.
  always_comb begin
    top_next = flags[0].valid ? values[0] : '0;
    if (op.ins) begin
      if (!flags[0].keep) begin
        top_next = height;
      end
    end else if (op.rem && flags[0].match) begin
      top_next = (MAX_ACTIVE > 1 && flags[1].valid) ? values[1] : '0;
    end
  end

  assign emit = accept && last_at_position && (top_next != last_emitted);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_emitted  <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        overflow_seen <= overflow_seen_next;
      end
      if (emit) begin
        out_valid    <= 1'b1;
        last_emitted <= top_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_position <= position;
      out_height   <= top_next;
      overflow     <= overflow_seen_next;
    end
  end

`ifndef SYNTHESIS
  generate
    for (i = 0; i < MAX_ACTIVE - 1; i++) begin : g_chk
      a_sorted: assert property (@(posedge clk) disable iff (rst)
        flags[i+1].valid |-> (flags[i].valid && values[i] >= values[i+1]))
        else $error("height chain lost its descending order");
    end
  endgenerate

  a_out_matches_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_height == last_emitted))
    else $error("held result differs from last emitted height");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |=> overflow_seen)
    else $error("overflow flag cleared without reset");

  a_full_start_flags: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_START && full) |=> overflow_seen)
    else $error("dropped start did not raise overflow");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !op.rem) |=> full)
    else $error("full chain lost an entry without a removal");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for skyline_outline_sweep
// Drives sorted building edge items with bursty valid and a stalling
// receiver. A behavioral copy of the active height table predicts every
// outline change, and each result is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
  import skos_pkg::*;

  localparam int HEIGHT_W   = DEF_HEIGHT_BITS;
  localparam int POS_W      = DEF_POS_BITS;
  localparam int TABLE_SIZE = DEF_MAX_ACTIVE;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [HEIGHT_W-1:0] hgt;
    logic                ovf;
  } outline_change_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                kind = KIND_START;
  logic [POS_W-1:0]    position = '0;
  logic [HEIGHT_W-1:0] height = '0;
  logic                last_at_position = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [POS_W-1:0]    out_position;
  logic [HEIGHT_W-1:0] out_height;
  logic                overflow;

  // Predicted state of the block.
  logic [HEIGHT_W-1:0] active_heights_q[$];
  logic [HEIGHT_W-1:0] shown_height = '0;
  logic                overflow_flag = 1'b0;
  outline_change_t     outline_changes_q[$];
  outline_change_t     want_change;

  // Traffic shaping.
  bit       sender_bursty = 1'b1;
  int       burst_left = 0;
  int       stall_mode = 0;
  logic [7:0] stall_pattern = 8'h5A;
  int       hold_cycles = 0;

  int       mismatches = 0;
  int       edges_sent = 0;
  int       changes_checked = 0;
  int       starts_dropped = 0;
  int       cycle_count = 0;

  skyline_outline_sweep #(
    .MAX_ACTIVE (TABLE_SIZE),
    .HEIGHT_BITS(HEIGHT_W),
    .POS_BITS   (POS_W)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .position        (position),
    .height          (height),
    .last_at_position(last_at_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_position    (out_position),
    .out_height      (out_height),
    .overflow        (overflow)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Updates the predicted table for one accepted item and queues the outline
  // change it causes, if any.
  function automatic void predict_outline(kind_t k, logic [POS_W-1:0] p,
                                          logic [HEIGHT_W-1:0] h, logic last);
    logic [HEIGHT_W-1:0] top;
    int hit;
    if (k == KIND_START) begin
      if (active_heights_q.size() < TABLE_SIZE) begin
        active_heights_q.push_back(h);
      end else begin
        overflow_flag = 1'b1;
        starts_dropped++;
      end
    end else begin
      hit = -1;
      for (int i = 0; i < active_heights_q.size(); i++) begin
        if (hit < 0 && active_heights_q[i] == h) hit = i;
      end
      if (hit >= 0) active_heights_q.delete(hit);
    end
    if (!last) return;
    top = '0;
    foreach (active_heights_q[i]) begin
      if (active_heights_q[i] > top) top = active_heights_q[i];
    end
    if (top == shown_height) return;
    shown_height = top;
    outline_changes_q.push_back('{pos: p, hgt: top, ovf: overflow_flag});
  endfunction

  task automatic send_edge(kind_t k, logic [POS_W-1:0] p, logic [HEIGHT_W-1:0] h,
                           logic last);
    int gap;
    @(negedge clk);
    if (sender_bursty && burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid         <= 1'b1;
    kind             <= k;
    position         <= p;
    height           <= h;
    last_at_position <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_outline(k, p, h, last);
    edges_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // The sender goes quiet until every predicted change has come out.
  task automatic drain_outline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outline_changes_q.size() > 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          out_stall     <= stall_pattern[0];
          stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (outline_changes_q.size() == 0) begin
        $error("unexpected result: out_position %0d out_height %0d overflow %0b",
               out_position, out_height, overflow);
        mismatches++;
      end else begin
        want_change = outline_changes_q.pop_front();
        if (out_position !== want_change.pos) begin
          $error("out_position: expected %0d, actual %0d", want_change.pos, out_position);
          mismatches++;
        end
        if (out_height !== want_change.hgt) begin
          $error("out_height: expected %0d, actual %0d", want_change.hgt, out_height);
          mismatches++;
        end
        if (overflow !== want_change.ovf) begin
          $error("overflow: expected %0b, actual %0b", want_change.ovf, overflow);
          mismatches++;
        end
        changes_checked++;
      end
    end
  end

  task automatic test_directed_edges();
    sender_bursty = 1'b1;
    stall_mode    = 1;
    send_edge(KIND_START, 16'd0,     16'hFFFF, 1'b1);
    // A second copy of the tallest height survives a single end item.
    send_edge(KIND_START, 16'd5,     16'hFFFF, 1'b0);
    send_edge(KIND_START, 16'd5,     16'd1,    1'b1);
    send_edge(KIND_END,   16'd10,    16'hFFFF, 1'b1);
    send_edge(KIND_END,   16'd10,    16'd7,    1'b1);
    send_edge(KIND_END,   16'd20,    16'hFFFF, 1'b1);
    send_edge(KIND_END,   16'd30,    16'd1,    1'b1);
    // A building of zero height never lifts the outline off the ground.
    send_edge(KIND_START, 16'd40,    16'd0,    1'b1);
    send_edge(KIND_START, 16'hAAAA,  16'h5555, 1'b1);
    // Position goes backward here; the block reports it as given.
    send_edge(KIND_END,   16'd3,     16'h5555, 1'b1);
    send_edge(KIND_END,   16'd3,     16'd0,    1'b0);
    send_edge(KIND_START, 16'hFFFF,  16'h8000, 1'b0);
    send_edge(KIND_END,   16'hFFFF,  16'h8000, 1'b1);
    send_edge(KIND_START, 16'hFFFF,  16'd2,    1'b1);
    send_edge(KIND_END,   16'd0,     16'd2,    1'b1);
    drain_outline();
  endtask

  task automatic test_backpressure();
    logic [POS_W-1:0] pos;
    sender_bursty = 1'b0;
    stall_mode    = 0;
    pos           = 16'h1000;
    @(posedge clk);
    hold_cycles = 300;
    // Rising heights and then falling ones: every item changes the outline.
    for (int i = 1; i <= 30; i++) begin
      pos = pos + 16'd7;
      send_edge(KIND_START, pos, HEIGHT_W'(i * 1000), 1'b1);
    end
    for (int i = 30; i >= 1; i--) begin
      pos = pos + 16'd7;
      send_edge(KIND_END, pos, HEIGHT_W'(i * 1000), 1'b1);
    end
    drain_outline();
  endtask

  task automatic test_random_skyline(int n_edges);
    logic [HEIGHT_W-1:0] open_heights[$];
    logic [HEIGHT_W-1:0] h;
    logic [POS_W-1:0]    pos;
    int sent;
    int group;
    int pick;
    int chunk;
    kind_t k;
    logic last;
    sent  = 0;
    chunk = 0;
    pos   = POS_W'($urandom_range(0, 65535));
    while (sent < n_edges) begin
      if (sent / 100 != chunk || sent == 0) begin
        chunk = sent / 100;
        if (chunk == 2) begin
          sender_bursty = 1'b0;
          stall_mode    = 0;
        end else begin
          sender_bursty = ($urandom_range(0, 3) != 0);
          stall_mode    = $urandom_range(0, 2);
          stall_pattern = 8'($urandom) & 8'hEE;
        end
      end
      pos   = pos + POS_W'($urandom_range(1, 400));
      group = $urandom_range(1, 4);
      for (int g = 0; g < group; g++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          // Stray end for a height that was most likely never started.
          k = KIND_END;
          h = HEIGHT_W'($urandom_range(1, 65535));
        end else if (open_heights.size() == 0 ||
                     (open_heights.size() < 48 && pick < 55)) begin
          k = KIND_START;
          if ($urandom_range(0, 1) == 0) h = HEIGHT_W'($urandom_range(1, 12));
          else h = HEIGHT_W'($urandom_range(1, 65535));
          open_heights.push_back(h);
        end else begin
          k    = KIND_END;
          pick = $urandom_range(0, open_heights.size() - 1);
          h    = open_heights[pick];
          open_heights.delete(pick);
        end
        last = (g == group - 1) ^ ($urandom_range(0, 29) == 0);
        send_edge(k, pos, h, last);
        sent++;
      end
      if ($urandom_range(0, 39) == 0) drain_outline();
    end
    while (open_heights.size() > 0) begin
      pos = pos + POS_W'($urandom_range(1, 50));
      send_edge(KIND_END, pos, open_heights.pop_front(), 1'b1);
    end
    drain_outline();
  endtask

  task automatic test_table_overflow();
    logic [HEIGHT_W-1:0] started[$];
    logic [HEIGHT_W-1:0] h;
    logic [POS_W-1:0]    pos;
    sender_bursty = 1'b1;
    stall_mode    = 1;
    pos           = 16'hF000;
    // More starts at one position than the table holds; the extras are lost.
    for (int i = 0; i < TABLE_SIZE + 6; i++) begin
      h = HEIGHT_W'($urandom_range(1, 65535));
      started.push_back(h);
      send_edge(KIND_START, pos, h, i == TABLE_SIZE + 5);
    end
    foreach (started[i]) begin
      pos = pos + 16'd3;
      send_edge(KIND_END, pos, started[i], 1'b1);
    end
    drain_outline();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_backpressure();
    test_random_skyline(390);
    test_table_overflow();
    drain_outline();
    repeat (10) @(posedge clk);
    if (outline_changes_q.size() != 0) begin
      $error("%0d predicted outline changes never came out", outline_changes_q.size());
      mismatches++;
    end
    $display("Sent %0d edge items (directed, long receiver hold, random skylines, full table).",
             edges_sent);
    $display("Checked %0d outline changes; %0d starts were dropped on a full table.",
             changes_checked, starts_dropped);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ skyline_outline_sweep.f @@
rtl/core/skos_pkg.sv
rtl/core/skos_cell.sv
rtl/core/skyline_outline_sweep.sv
bench/testbench.sv
